// File: hw/rtl/quadratic_bezier_tone_curve_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tone curve block
// Each macro checks a property on clk with rst_n low disabling the check.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_BEZIER_TONE_CURVE_ASSERT_SVH
`define QUADRATIC_BEZIER_TONE_CURVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QBTC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qbtc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QBTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qbtc assertion failed");

`endif

// File: hw/rtl/qbtc_pkg.sv
// ----------------------------------------------------------------------------
// qbtc_pkg
// Register indexes and state types shared by the tone curve modules.
// ----------------------------------------------------------------------------
package qbtc_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LEVEL = 3'd0,
    REG_END_LEVEL   = 3'd1,
    REG_CTRL_X      = 3'd2,
    REG_CTRL_Y      = 3'd3,
    REG_STEP_SIZE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_SEND
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

endpackage

// File: hw/rtl/quadratic_bezier_tone_curve.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_tone_curve
// Quadratic Bezier tone curve lookup by linear search over t.
// ----------------------------------------------------------------------------
// Each position is set up in the front, where a bit-serial multiplier forms
// the forward differences. The back then takes the beat and advances t by
// one step per cycle, until the search finds a distance that does not
// shrink or runs past 1 + step_size. The setup of the next position
// overlaps the search of the current one, so the back search loop sets the
// rate. Configuration is to be written by the user only while the block is
// idle; the block itself does not enforce this.
module quadratic_bezier_tone_curve #(
  parameter int FRAC_BITS  = 16,
  parameter int LEVEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic [FRAC_BITS:0]                  in_x_pos,
  output logic                                in_full,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic [31:0]                         out_y_value,
  output logic [FRAC_BITS+1:0]                out_t_found,
  output logic                                out_ran_to_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qbtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [((LEVEL_BITS > FRAC_BITS + 1) ? LEVEL_BITS : FRAC_BITS + 1)-1:0] cfg_data
);

  localparam int F  = FRAC_BITS;
  localparam int L  = LEVEL_BITS;
  localparam int W  = F + 1;
  localparam int TW = F + 2;
  localparam int DW = 3 * F + 5;
  localparam int YW = L + 2 * F + 6;
  localparam int RW = 3 * DW + 3 * YW + W;
  localparam int OW = 32 + TW + 1;

  logic [L-1:0]  start_level_r, end_level_r, ctrl_y_r;
  logic [W-1:0]  ctrl_x_r, step_size_r;
  logic          rec_push, rec_full, rec_pop, rec_empty;
  logic [RW-1:0] rec_wdata, rec_rdata;
  logic          res_push, res_full;
  logic [OW-1:0] res_wdata, res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_level_r <= '0;
      end_level_r   <= '1;
      ctrl_x_r      <= W'(1) << (F - 1);
      ctrl_y_r      <= L'(1) << (L - 1);
      step_size_r   <= W'(1) << F >> 10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qbtc_pkg::REG_START_LEVEL: start_level_r <= cfg_data[L-1:0];
        qbtc_pkg::REG_END_LEVEL:   end_level_r   <= cfg_data[L-1:0];
        qbtc_pkg::REG_CTRL_X:      ctrl_x_r      <= cfg_data[W-1:0];
        qbtc_pkg::REG_CTRL_Y:      ctrl_y_r      <= cfg_data[L-1:0];
        qbtc_pkg::REG_STEP_SIZE:   step_size_r   <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  qbtc_front #(
    .FRAC_BITS  (F),
    .LEVEL_BITS (L)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .x_pos       (in_x_pos),
    .full        (in_full),
    .start_level (start_level_r),
    .end_level   (end_level_r),
    .ctrl_x      (ctrl_x_r),
    .ctrl_y      (ctrl_y_r),
    .step_size   (step_size_r),
    .rec_push    (rec_push),
    .rec_full    (rec_full),
    .rec_data    (rec_wdata)
  );

  qbtc_fifo #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_rec_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rec_push),
    .wr_data (rec_wdata),
    .full    (rec_full),
    .pop     (rec_pop),
    .rd_data (rec_rdata),
    .empty   (rec_empty)
  );

  qbtc_back #(
    .FRAC_BITS  (F),
    .LEVEL_BITS (L)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .end_level (end_level_r),
    .rec_pop   (rec_pop),
    .rec_empty (rec_empty),
    .rec_data  (rec_rdata),
    .out_push  (res_push),
    .out_full  (res_full),
    .out_data  (res_wdata)
  );

  qbtc_fifo #(
    .WIDTH (OW),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wdata),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rdata),
    .empty   (out_empty)
  );

  assign out_y_value    = res_rdata[OW-1 -: 32];
  assign out_t_found    = res_rdata[TW:1];
  assign out_ran_to_end = res_rdata[0];

endmodule

// File: hw/rtl/qbtc_fifo.sv
// ----------------------------------------------------------------------------
// qbtc_fifo
// Small register queue with a combinational head and occupancy flags.
// ----------------------------------------------------------------------------
module qbtc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/qbtc_front.sv
// ----------------------------------------------------------------------------
// qbtc_front
// Takes a position and builds the start values and forward differences
// of the distance and level polynomials with a bit-serial multiplier.
// ----------------------------------------------------------------------------
module qbtc_front #(
  parameter int FRAC_BITS  = 16,
  parameter int LEVEL_BITS = 16,
  localparam int W  = FRAC_BITS + 1,
  localparam int DW = 3 * FRAC_BITS + 5,
  localparam int YW = LEVEL_BITS + 2 * FRAC_BITS + 6,
  localparam int RW = 3 * DW + 3 * YW + W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [W-1:0]          x_pos,
  output logic                  full,
  input  logic [LEVEL_BITS-1:0] start_level,
  input  logic [LEVEL_BITS-1:0] end_level,
  input  logic [W-1:0]          ctrl_x,
  input  logic [LEVEL_BITS-1:0] ctrl_y,
  input  logic [W-1:0]          step_size,
  output logic                  rec_push,
  input  logic                  rec_full,
  output logic [RW-1:0]         rec_data
);

  localparam int F  = FRAC_BITS;
  localparam int CW = $clog2(W);
  localparam logic [DW-1:0] ONE_D = DW'(1) << F;

  typedef struct packed {
    logic [DW-1:0] d;
    logic [DW-1:0] dd;
    logic [DW-1:0] ddd;
    logic [YW-1:0] y;
    logic [YW-1:0] dy;
    logic [YW-1:0] ddy;
    logic [W-1:0]  step;
  } rec_t;

  qbtc_pkg::front_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [DW-1:0] mcd_r [2], mcd_nxt [2];
  logic [DW-1:0] acd_r [2], acd_nxt [2];
  logic [YW-1:0] mcy_r [2], mcy_nxt [2];
  logic [YW-1:0] acy_r [2], acy_nxt [2];
  logic [DW-1:0] sum_d [2];
  logic [YW-1:0] sum_y [2];
  logic [DW-1:0] coef_a, coef_b;
  logic [YW-1:0] coef_ay, coef_by;
  logic          last_bit;
  rec_t          rec;

  // X(t) - x = a*t^2 + b*t - x, all scaled to three fraction widths.
  assign coef_a  = ONE_D - (DW'(ctrl_x) << 1);
  assign coef_b  = DW'(ctrl_x) << (F + 1);
  // Y(t) = start + by*t + ay*t^2, scaled to two fraction widths.
  assign coef_ay = YW'(start_level) + YW'(end_level) - (YW'(ctrl_y) << 1);
  assign coef_by = (YW'(ctrl_y) - YW'(start_level)) << (F + 1);

  assign last_bit = (cnt_r == CW'(W - 1));

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sum_d[k] = acd_r[k] + (sh_r[0] ? mcd_r[k] : '0);
      sum_y[k] = acy_r[k] + (sh_r[0] ? mcy_r[k] : '0);
    end
  end

  always_comb begin
    rec.d    = '0 - (DW'(x_r) << (2 * F));
    rec.dd   = acd_r[0];
    rec.ddd  = acd_r[1] << 1;
    rec.y    = YW'(start_level) << (2 * F);
    rec.dy   = acy_r[0];
    rec.ddy  = acy_r[1] << 1;
    rec.step = step_size;
  end
  assign rec_data = rec;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    sh_nxt    = sh_r;
    mcd_nxt   = mcd_r;
    acd_nxt   = acd_r;
    mcy_nxt   = mcy_r;
    acy_nxt   = acy_r;
    full      = 1'b1;
    rec_push  = 1'b0;
    unique case (state_r)
      qbtc_pkg::F_IDLE: begin
        full = 1'b0;
        if (push) begin
          x_nxt      = x_pos;
          sh_nxt     = step_size;
          cnt_nxt    = '0;
          mcd_nxt[0] = coef_a;
          mcd_nxt[1] = '0;
          mcy_nxt[0] = coef_ay;
          mcy_nxt[1] = '0;
          acd_nxt[0] = '0;
          acd_nxt[1] = '0;
          acy_nxt[0] = '0;
          acy_nxt[1] = '0;
          state_nxt  = qbtc_pkg::F_MUL1;
        end
      end
      qbtc_pkg::F_MUL1, qbtc_pkg::F_MUL2: begin
        for (int k = 0; k < 2; k++) begin
          acd_nxt[k] = sum_d[k];
          acy_nxt[k] = sum_y[k];
          mcd_nxt[k] = mcd_r[k] << 1;
          mcy_nxt[k] = mcy_r[k] << 1;
        end
        sh_nxt  = sh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (last_bit && state_r == qbtc_pkg::F_MUL1) begin
          // Second pass multiplies (a*s + b) and a*s by the step once more.
          mcd_nxt[0] = sum_d[0] + coef_b;
          mcd_nxt[1] = sum_d[0];
          mcy_nxt[0] = sum_y[0] + coef_by;
          mcy_nxt[1] = sum_y[0];
          acd_nxt[0] = '0;
          acd_nxt[1] = '0;
          acy_nxt[0] = '0;
          acy_nxt[1] = '0;
          sh_nxt     = step_size;
          cnt_nxt    = '0;
          state_nxt  = qbtc_pkg::F_MUL2;
        end else if (last_bit) begin
          state_nxt = qbtc_pkg::F_SEND;
        end
      end
      qbtc_pkg::F_SEND: begin
        if (!rec_full) begin
          rec_push  = 1'b1;
          state_nxt = qbtc_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = qbtc_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qbtc_pkg::F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    sh_r  <= sh_nxt;
    mcd_r <= mcd_nxt;
    acd_r <= acd_nxt;
    mcy_r <= mcy_nxt;
    acy_r <= acy_nxt;
  end

endmodule

// File: hw/rtl/qbtc_back.sv
// ----------------------------------------------------------------------------
// qbtc_back
// Steps t one increment per cycle by forward differences, stops at the
// first step whose distance does not shrink and emits the saturated level.
// ----------------------------------------------------------------------------
`include "quadratic_bezier_tone_curve_assert.svh"

module qbtc_back #(
  parameter int FRAC_BITS  = 16,
  parameter int LEVEL_BITS = 16,
  localparam int W  = FRAC_BITS + 1,
  localparam int TW = FRAC_BITS + 2,
  localparam int DW = 3 * FRAC_BITS + 5,
  localparam int YW = LEVEL_BITS + 2 * FRAC_BITS + 6,
  localparam int RW = 3 * DW + 3 * YW + W,
  localparam int OW = 32 + TW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [LEVEL_BITS-1:0] end_level,
  output logic                  rec_pop,
  input  logic                  rec_empty,
  input  logic [RW-1:0]         rec_data,
  output logic                  out_push,
  input  logic                  out_full,
  output logic [OW-1:0]         out_data
);

  localparam int F  = FRAC_BITS;
  localparam int YS = LEVEL_BITS + FRAC_BITS;
  localparam int YO = (YS > 32) ? YS : 32;
  localparam logic [TW-1:0] ONE_T = TW'(1) << F;
  localparam logic [DW-1:0] LAST_INIT = DW'(1) << (3 * F + 1);

  typedef struct packed {
    logic [DW-1:0] d;
    logic [DW-1:0] dd;
    logic [DW-1:0] ddd;
    logic [YW-1:0] y;
    logic [YW-1:0] dy;
    logic [YW-1:0] ddy;
    logic [W-1:0]  step;
  } rec_t;

  typedef struct packed {
    logic [31:0]   y_value;
    logic [TW-1:0] t_found;
    logic          ran_to_end;
  } res_t;

  qbtc_pkg::back_state_t state_r, state_nxt;
  logic [DW-1:0] d_r, d_nxt, dd_r, dd_nxt, ddd_r, ddd_nxt;
  logic [YW-1:0] y_r, y_nxt, dy_r, dy_nxt, ddy_r, ddy_nxt;
  logic [W-1:0]  s_r, s_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [DW-1:0] last_r, last_nxt;
  rec_t          rec;
  res_t          res;
  logic [DW-1:0] abs_d;
  logic          over, found, done;
  logic signed [YW-1:0] y_sh;
  logic [YS-1:0] y_sat;
  logic [YO-1:0] y_ext;

  assign rec   = rec_data;
  assign abs_d = d_r[DW-1] ? (~d_r + 1'b1) : d_r;
  assign over  = (t_r > (ONE_T + TW'(s_r)));
  assign found = !over && (abs_d >= last_r);
  assign done  = (state_r == qbtc_pkg::B_RUN) && (over || found);

  // Floor to one fraction width, then clamp to the level range.
  always_comb begin
    y_sh = $signed(y_r) >>> F;
    if (over) begin
      y_sat = {end_level, {F{1'b0}}};
    end else if (y_r[YW-1]) begin
      y_sat = '0;
    end else if (|y_sh[YW-1:YS]) begin
      y_sat = '1;
    end else begin
      y_sat = y_sh[YS-1:0];
    end
    y_ext = YO'(y_sat);
  end

  always_comb begin
    res.y_value    = y_ext[31:0];
    res.t_found    = over ? ONE_T : t_r;
    res.ran_to_end = over;
  end
  assign out_data = res;

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    dd_nxt    = dd_r;
    ddd_nxt   = ddd_r;
    y_nxt     = y_r;
    dy_nxt    = dy_r;
    ddy_nxt   = ddy_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    last_nxt  = last_r;
    rec_pop   = 1'b0;
    out_push  = 1'b0;
    unique case (state_r)
      qbtc_pkg::B_IDLE: begin
        if (!rec_empty) begin
          rec_pop   = 1'b1;
          d_nxt     = rec.d;
          dd_nxt    = rec.dd;
          ddd_nxt   = rec.ddd;
          y_nxt     = rec.y;
          dy_nxt    = rec.dy;
          ddy_nxt   = rec.ddy;
          s_nxt     = rec.step;
          t_nxt     = '0;
          last_nxt  = LAST_INIT;
          state_nxt = qbtc_pkg::B_RUN;
        end
      end
      qbtc_pkg::B_RUN: begin
        if (done) begin
          if (!out_full) begin
            out_push  = 1'b1;
            state_nxt = qbtc_pkg::B_IDLE;
          end
        end else begin
          last_nxt = abs_d;
          d_nxt    = d_r + dd_r;
          dd_nxt   = dd_r + ddd_r;
          y_nxt    = y_r + dy_r;
          dy_nxt   = dy_r + ddy_r;
          t_nxt    = t_r + TW'(s_r);
        end
      end
      default: begin
        state_nxt = qbtc_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qbtc_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    dd_r   <= dd_nxt;
    ddd_r  <= ddd_nxt;
    y_r    <= y_nxt;
    dy_r   <= dy_nxt;
    ddy_r  <= ddy_nxt;
    s_r    <= s_nxt;
    t_r    <= t_nxt;
    last_r <= last_nxt;
  end

  // A finished search waits in place while the result queue is full.
  `QBTC_ASSERT_NEXT(a_hold_on_full, done && out_full, state_r == qbtc_pkg::B_RUN)
  // Taking a new beat always restarts the search at t equal zero.
  `QBTC_ASSERT_NEXT(a_start_at_zero, rec_pop, state_r == qbtc_pkg::B_RUN && t_r == '0)
  // Every step that continues the search has a strictly smaller distance.
  `QBTC_ASSERT_NEXT(a_dist_shrinks, state_r == qbtc_pkg::B_RUN && !done,
                    last_r < $past(last_r))

endmodule

// File: verif/quadratic_bezier_tone_curve_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_bezier_tone_curve_test
// Drives positions through the tone curve block under several register
// settings and checks every result beat against a predictor of the search.
// ----------------------------------------------------------------------------
module quadratic_bezier_tone_curve_test;

  localparam int        FRAC_BITS  = 16;
  localparam int        LEVEL_BITS = 16;
  localparam int        CFG_W      = 17;
  localparam longint    ONE        = 64'sd1 << FRAC_BITS;
  localparam longint    CYCLE_CAP  = 4000000;

  typedef struct packed {
    logic [31:0]          y_value;
    logic [FRAC_BITS+1:0] t_found;
    logic                 ran_to_end;
  } curve_point_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic [FRAC_BITS:0]   in_x_pos;
  logic                 in_full;
  logic                 out_pop;
  logic                 out_empty;
  logic [31:0]          out_y_value;
  logic [FRAC_BITS+1:0] out_t_found;
  logic                 out_ran_to_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [qbtc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Register shadow used by the predictor.
  longint start_lvl, end_lvl, cx_reg, cy_reg, step_reg;

  logic [FRAC_BITS:0] pending_x[$];
  curve_point_t       expected_pts[$];
  int                 queued_cnt;
  int                 accepted_cnt;
  int                 fail_cnt;
  int                 send_gap;
  int                 pop_gap;
  bit                 calm;
  longint             cycle_cnt;

  quadratic_bezier_tone_curve #(
    .FRAC_BITS (FRAC_BITS),
    .LEVEL_BITS(LEVEL_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_x_pos      (in_x_pos),
    .in_full       (in_full),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_y_value   (out_y_value),
    .out_t_found   (out_t_found),
    .out_ran_to_end(out_ran_to_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Distance |X(t) - x| scaled by ONE^3, so the comparison is exact.
  function automatic longint x_error(longint t, longint x);
    longint d;
    d = 2 * (ONE - t) * t * cx_reg + t * t * ONE - x * ONE * ONE;
    return (d < 0) ? -d : d;
  endfunction

  function automatic curve_point_t predict_curve(logic [FRAC_BITS:0] x_in);
    curve_point_t pt;
    longint       t, u, best, d, y, ymax;
    bit           hit;
    t    = 0;
    best = 2 * ONE * ONE * ONE;
    hit  = 1'b0;
    while (t <= ONE + step_reg) begin
      d = x_error(t, longint'(x_in));
      if (d >= best) begin
        hit = 1'b1;
        break;
      end
      best = d;
      t += step_reg;
    end
    if (!hit) t = ONE;
    u = ONE - t;
    y = (u * u * start_lvl + 2 * u * t * cy_reg + t * t * end_lvl) >>> FRAC_BITS;
    ymax = (64'sd1 << (LEVEL_BITS + FRAC_BITS)) - 1;
    if (y < 0) y = 0;
    if (y > ymax) y = ymax;
    pt.y_value    = y[31:0];
    pt.t_found    = t[FRAC_BITS+1:0];
    pt.ran_to_end = !hit;
    return pt;
  endfunction

  // Sender: one beat per accepted push, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push  <= 1'b0;
      in_x_pos <= '0;
      send_gap = 0;
    end else begin
      if (in_push && !in_full) begin
        expected_pts.push_back(predict_curve(in_x_pos));
        accepted_cnt++;
      end
      if (!(in_push && in_full)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (pending_x.size() > 0) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 18);
            in_push <= 1'b0;
          end else begin
            in_push  <= 1'b1;
            in_x_pos <= pending_x.pop_front();
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each popped beat against the oldest prediction.
  always @(posedge clk) begin
    curve_point_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_pts.size() == 0) begin
          $error("result beat with nothing expected: y_value %0h", out_y_value);
          fail_cnt++;
        end else begin
          want = expected_pts.pop_front();
          if (out_y_value !== want.y_value) begin
            $error("y_value: expected %0h, actual %0h", want.y_value, out_y_value);
            fail_cnt++;
          end
          if (out_t_found !== want.t_found) begin
            $error("t_found: expected %0h, actual %0h", want.t_found, out_t_found);
            fail_cnt++;
          end
          if (out_ran_to_end !== want.ran_to_end) begin
            $error("ran_to_end: expected %0b, actual %0b", want.ran_to_end,
                   out_ran_to_end);
            fail_cnt++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop_gap = $urandom_range(0, 18);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("quadratic_bezier_tone_curve_test failed");
      $finish;
    end
  end

  task automatic write_reg(qbtc_pkg::cfg_reg_t idx, longint val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      qbtc_pkg::REG_START_LEVEL: start_lvl = val & 64'hFFFF;
      qbtc_pkg::REG_END_LEVEL:   end_lvl   = val & 64'hFFFF;
      qbtc_pkg::REG_CTRL_X:      cx_reg    = val & 64'h1FFFF;
      qbtc_pkg::REG_CTRL_Y:      cy_reg    = val & 64'hFFFF;
      qbtc_pkg::REG_STEP_SIZE:   step_reg  = val & 64'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic set_curve(longint s, longint e, longint cx, longint cy, longint st);
    write_reg(qbtc_pkg::REG_START_LEVEL, s);
    write_reg(qbtc_pkg::REG_END_LEVEL, e);
    write_reg(qbtc_pkg::REG_CTRL_X, cx);
    write_reg(qbtc_pkg::REG_CTRL_Y, cy);
    write_reg(qbtc_pkg::REG_STEP_SIZE, st);
  endtask

  task automatic queue_x(int x);
    pending_x.push_back(x[FRAC_BITS:0]);
    queued_cnt++;
  endtask

  // Holds the test sequence until every queued position has produced its result.
  task automatic drain;
    while (accepted_cnt != queued_cnt || expected_pts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic longint pick_level();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_x_pos   = '0;
    out_pop    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    queued_cnt = 0;
    accepted_cnt = 0;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    start_lvl  = 0;
    end_lvl    = 65535;
    cx_reg     = ONE / 2;
    cy_reg     = 32768;
    step_reg   = ONE >> 10;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: ends of the range, midpoint and alternating bit patterns.
    queue_x(0);
    queue_x(65536);
    queue_x(1);
    queue_x(32768);
    queue_x(65535);
    queue_x(32'h0AAAA);
    queue_x(32'h15555);
    drain();

    // Falling curve with the smallest step: the longest searches.
    set_curve(65535, 0, 0, 65535, 1);
    queue_x(0);
    queue_x(65536);
    drain();

    // Step of one: t advances in whole units, so t_found is a whole multiple of one.
    set_curve(0, 65535, 65536, 0, 65536);
    queue_x(0);
    queue_x(32768);
    queue_x(65536);
    queue_x(1);
    drain();

    set_curve(65535, 65535, 12345, 0, 1024);
    queue_x(0);
    queue_x(65536);
    queue_x(40000);
    queue_x(200);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_curve(pick_level(), pick_level(),
                ($urandom_range(0, 5) == 0) ? 65536 : $urandom_range(0, 65536),
                pick_level(),
                ($urandom_range(0, 9) == 0) ? 65536 : $urandom_range(256, 65536));
      calm = (ph == 7);
      for (int n = 0; n < 60; n++) begin
        case ($urandom_range(0, 9))
          0:       queue_x(0);
          1:       queue_x(65536);
          default: queue_x(int'($urandom_range(0, 65536)));
        endcase
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("quadratic_bezier_tone_curve_test passed");
    end else begin
      $display("quadratic_bezier_tone_curve_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/qbtc_pkg.sv
hw/rtl/qbtc_fifo.sv
hw/rtl/qbtc_front.sv
hw/rtl/qbtc_back.sv
hw/rtl/quadratic_bezier_tone_curve.sv
verif/quadratic_bezier_tone_curve_test.sv
